FILE: rtl/core/fdtd_pml_pkg.sv
// Shared types, widths and codes for the FDTD cell update kernel with an absorbing layer.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package fdtd_pml_pkg;

    // Field format and derived widths
    localparam int FIELD_WIDTH = 32;
    localparam int CURL_W      = FIELD_WIDTH + 2;
    localparam int SUM_W       = CURL_W + 4;
    localparam int LOSS_W      = 32;
    localparam int GAIN_W      = 18;
    localparam int INV_W       = 17;
    localparam int SIGMA_W     = 16;
    localparam int CMD_W       = 2;
    localparam int MULT_A_W    = SIGMA_W + 1;
    localparam int ARAW_W      = MULT_A_W + LOSS_W;
    localparam int ADIEL_W     = ARAW_W + 1;
    localparam int DEN_W       = 34;
    localparam int REM_W       = DEN_W + 1;
    localparam int Q_W         = 32;
    localparam int COEF_W      = 34;
    localparam int DIV_STAGES  = 16;
    localparam int DIV_STEPS   = Q_W / DIV_STAGES;
    localparam int PO_W        = FIELD_WIDTH + Q_W;
    localparam int PC_W        = CURL_W + COEF_W;

    // Port widths
    localparam int IN_DATA_W   = 200;
    localparam int OUT_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Commands
    localparam logic [CMD_W-1:0] CMD_HX  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_HZ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_H_LOSS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_E_LOSS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_H_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_E_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV    = 3'd4;

    // Reset values and fixed constants
    localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd46341;
    localparam logic [INV_W-1:0]  INV_RESET  = 17'd16804;
    localparam logic [INV_W-1:0]  INV_ONE    = 17'h10000;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [LOSS_W-1:0] h_loss;
        logic [LOSS_W-1:0] e_loss;
        logic [GAIN_W-1:0] h_gain;
        logic [GAIN_W-1:0] e_gain;
        logic [INV_W-1:0]  inv;
    } cfg_t;

    // Side payload that rides along the divider
    typedef struct packed {
        logic                          nop;
        logic                          sat;
        logic signed [FIELD_WIDTH-1:0] old;
        logic signed [CURL_W-1:0]      curl;
        logic [GAIN_W-1:0]             gain;
    } item_t;

    // Divider working state
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   num;
        logic [Q_W-1:0]   quo;
    } div_t;

endpackage

FILE: rtl/core/fdtd_pml_front.sv
// Front end: loss term, curl, dielectric scaling and divider setup in three stages.
// Depends on fdtd_pml_pkg.
module fdtd_pml_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      ce,
    input  logic                                      in_valid,
    input  logic [fdtd_pml_pkg::CMD_W-1:0]            command,
    input  logic signed [fdtd_pml_pkg::FIELD_WIDTH-1:0] old_value,
    input  logic signed [fdtd_pml_pkg::FIELD_WIDTH-1:0] field_a,
    input  logic signed [fdtd_pml_pkg::FIELD_WIDTH-1:0] field_b,
    input  logic signed [fdtd_pml_pkg::FIELD_WIDTH-1:0] field_c,
    input  logic signed [fdtd_pml_pkg::FIELD_WIDTH-1:0] field_d,
    input  logic [fdtd_pml_pkg::SIGMA_W-1:0]          sigma_x,
    input  logic [fdtd_pml_pkg::SIGMA_W-1:0]          sigma_y,
    input  logic                                      in_dielectric,
    input  fdtd_pml_pkg::cfg_t                        cfg,
    output logic                                      out_valid,
    output fdtd_pml_pkg::div_t                        out_div,
    output fdtd_pml_pkg::item_t                       out_item
);

    // Stage 1 registers
    logic                                        s1_valid_reg;
    logic [fdtd_pml_pkg::CMD_W-1:0]              s1_cmd_reg;
    logic                                        s1_diel_reg;
    logic [fdtd_pml_pkg::ARAW_W-1:0]             s1_a_reg;
    logic [fdtd_pml_pkg::ARAW_W-1:0]             s1_a_next;
    logic signed [fdtd_pml_pkg::CURL_W-1:0]      s1_curl_reg;
    logic signed [fdtd_pml_pkg::CURL_W-1:0]      s1_curl_next;
    logic signed [fdtd_pml_pkg::FIELD_WIDTH-1:0] s1_old_reg;
    logic [fdtd_pml_pkg::MULT_A_W-1:0]           mult_a;
    logic [fdtd_pml_pkg::LOSS_W-1:0]             mult_b;
    logic signed [fdtd_pml_pkg::CURL_W-1:0]      diff_ab;
    logic signed [fdtd_pml_pkg::CURL_W-1:0]      diff_cd;

    // Stage 2 registers
    logic                                        s2_valid_reg;
    logic                                        s2_nop_reg;
    logic [fdtd_pml_pkg::ADIEL_W-1:0]            s2_a_reg;
    logic [fdtd_pml_pkg::ADIEL_W-1:0]            s2_a_next;
    logic [fdtd_pml_pkg::GAIN_W-1:0]             s2_gain_reg;
    logic [fdtd_pml_pkg::GAIN_W-1:0]             s2_gain_next;
    logic signed [fdtd_pml_pkg::CURL_W-1:0]      s2_curl_reg;
    logic signed [fdtd_pml_pkg::FIELD_WIDTH-1:0] s2_old_reg;
    logic [fdtd_pml_pkg::ARAW_W+fdtd_pml_pkg::INV_W-1:0] a_scaled;
    logic [fdtd_pml_pkg::GAIN_W+fdtd_pml_pkg::INV_W-1:0] g_scaled;
    logic                                        use_diel;

    // Stage 3 registers
    logic                                        s3_valid_reg;
    fdtd_pml_pkg::div_t                          s3_div_reg;
    fdtd_pml_pkg::div_t                          s3_div_next;
    fdtd_pml_pkg::item_t                         s3_item_reg;
    logic                                        a_over;
    logic [fdtd_pml_pkg::DEN_W-1:0]              a_clip;

    // Stage 1: select the conductivity and loss factors, form the curl
    always_comb
    begin
        case (command)
            fdtd_pml_pkg::CMD_HX:
            begin
                mult_a = fdtd_pml_pkg::MULT_A_W'(sigma_x);
                mult_b = cfg.h_loss;
            end
            fdtd_pml_pkg::CMD_EY:
            begin
                mult_a = fdtd_pml_pkg::MULT_A_W'(sigma_x) + fdtd_pml_pkg::MULT_A_W'(sigma_y);
                mult_b = cfg.e_loss;
            end
            default:
            begin
                mult_a = fdtd_pml_pkg::MULT_A_W'(sigma_y);
                mult_b = cfg.h_loss;
            end
        endcase
    end

    assign s1_a_next = fdtd_pml_pkg::ARAW_W'(mult_a) * fdtd_pml_pkg::ARAW_W'(mult_b);
    assign diff_ab   = fdtd_pml_pkg::CURL_W'(field_a) - fdtd_pml_pkg::CURL_W'(field_b);
    assign diff_cd   = fdtd_pml_pkg::CURL_W'(field_c) - fdtd_pml_pkg::CURL_W'(field_d);

    always_comb
    begin
        case (command)
            fdtd_pml_pkg::CMD_HX: s1_curl_next = -diff_ab;
            fdtd_pml_pkg::CMD_EY: s1_curl_next = diff_ab - diff_cd;
            default:              s1_curl_next = diff_ab;
        endcase
    end

    // Stage 2: for Ey updates in dielectric cells, scale loss and gain by 1/eps_r, rounding half up
    assign use_diel = (s1_cmd_reg == fdtd_pml_pkg::CMD_EY) && s1_diel_reg;
    assign a_scaled = (fdtd_pml_pkg::ARAW_W+fdtd_pml_pkg::INV_W)'(s1_a_reg) * cfg.inv
                      + (fdtd_pml_pkg::ARAW_W+fdtd_pml_pkg::INV_W)'(17'h08000);
    assign g_scaled = (fdtd_pml_pkg::GAIN_W+fdtd_pml_pkg::INV_W)'(cfg.e_gain) * cfg.inv
                      + (fdtd_pml_pkg::GAIN_W+fdtd_pml_pkg::INV_W)'(17'h08000);

    always_comb
    begin
        if (use_diel)
        begin
            s2_a_next    = a_scaled[16 +: fdtd_pml_pkg::ADIEL_W];
            s2_gain_next = g_scaled[16 +: fdtd_pml_pkg::GAIN_W];
        end
        else
        begin
            s2_a_next    = fdtd_pml_pkg::ADIEL_W'(s1_a_reg);
            s2_gain_next = (s1_cmd_reg == fdtd_pml_pkg::CMD_EY) ? cfg.e_gain : cfg.h_gain;
        end
    end

    // Stage 3: clip the loss at one and set up the rounded reciprocal division
    assign a_over = s2_a_reg > fdtd_pml_pkg::ADIEL_W'(64'h1_0000_0000);
    assign a_clip = a_over ? fdtd_pml_pkg::DEN_W'(64'h1_0000_0000)
                           : fdtd_pml_pkg::DEN_W'(s2_a_reg[32:0]);

    always_comb
    begin
        s3_div_next.den = fdtd_pml_pkg::DEN_W'(64'h1_0000_0000) + a_clip;
        s3_div_next.rem = fdtd_pml_pkg::REM_W'(64'h8000_0000)
                          + fdtd_pml_pkg::REM_W'(s3_div_next.den[fdtd_pml_pkg::DEN_W-1]);
        s3_div_next.num = s3_div_next.den[fdtd_pml_pkg::Q_W:1];
        s3_div_next.quo = '0;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_cmd_reg       <= command;
            s1_diel_reg      <= in_dielectric;
            s1_a_reg         <= s1_a_next;
            s1_curl_reg      <= s1_curl_next;
            s1_old_reg       <= old_value;
            s2_nop_reg       <= (s1_cmd_reg == fdtd_pml_pkg::CMD_NOP);
            s2_a_reg         <= s2_a_next;
            s2_gain_reg      <= s2_gain_next;
            s2_curl_reg      <= s1_curl_reg;
            s2_old_reg       <= s1_old_reg;
            s3_div_reg       <= s3_div_next;
            s3_item_reg.nop  <= s2_nop_reg;
            s3_item_reg.sat  <= a_over;
            s3_item_reg.old  <= s2_old_reg;
            s3_item_reg.curl <= s2_curl_reg;
            s3_item_reg.gain <= s2_gain_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_div   = s3_div_reg;
    assign out_item  = s3_item_reg;

`ifndef SYNTHESIS
    // The divisor handed to the divider always lies between one and two.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_div_reg.den[fdtd_pml_pkg::DEN_W-1:fdtd_pml_pkg::DEN_W-2] != 2'b00)
            && (!s3_div_reg.den[fdtd_pml_pkg::DEN_W-1] || (s3_div_reg.den[32:0] == '0)))
        else $error("front: divisor out of range");
`endif

endmodule

FILE: rtl/core/fdtd_pml_div.sv
// Pipelined restoring divider for absorb = round(2^63 / den), two quotient bits per stage.
// Carries the item payload alongside; depends on fdtd_pml_pkg.
module fdtd_pml_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           ce,
    input  logic                           in_valid,
    input  fdtd_pml_pkg::div_t             in_div,
    input  fdtd_pml_pkg::item_t            in_item,
    output logic                           out_valid,
    output logic [fdtd_pml_pkg::Q_W-1:0]   out_quo,
    output fdtd_pml_pkg::item_t            out_item
);

    logic                 valid_reg [fdtd_pml_pkg::DIV_STAGES];
    fdtd_pml_pkg::div_t   div_reg   [fdtd_pml_pkg::DIV_STAGES];
    fdtd_pml_pkg::item_t  item_reg  [fdtd_pml_pkg::DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < fdtd_pml_pkg::DIV_STAGES; g++)
        begin : g_stage
            logic                            stage_valid;
            fdtd_pml_pkg::div_t              stage_in;
            fdtd_pml_pkg::item_t             stage_item;
            fdtd_pml_pkg::div_t              div_next;
            logic [fdtd_pml_pkg::REM_W-1:0]  trial;

            if (g == 0)
            begin : g_first
                assign stage_valid = in_valid;
                assign stage_in    = in_div;
                assign stage_item  = in_item;
            end
            else
            begin : g_rest
                assign stage_valid = valid_reg[g-1];
                assign stage_in    = div_reg[g-1];
                assign stage_item  = item_reg[g-1];
            end

            // For each quotient bit of the stage, shift in the next numerator bit, subtract the divisor where it fits
            always_comb
            begin
                div_next = stage_in;
                trial    = '0;
                for (int k = 0; k < fdtd_pml_pkg::DIV_STEPS; k++)
                begin
                    trial = {div_next.rem[fdtd_pml_pkg::REM_W-2:0],
                             div_next.num[fdtd_pml_pkg::Q_W-1]};
                    div_next.num = {div_next.num[fdtd_pml_pkg::Q_W-2:0], 1'b0};
                    if (trial >= fdtd_pml_pkg::REM_W'(div_next.den))
                    begin
                        div_next.rem = trial - fdtd_pml_pkg::REM_W'(div_next.den);
                        div_next.quo = {div_next.quo[fdtd_pml_pkg::Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        div_next.rem = trial;
                        div_next.quo = {div_next.quo[fdtd_pml_pkg::Q_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (ce)
                begin
                    valid_reg[g] <= stage_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    div_reg[g]  <= div_next;
                    item_reg[g] <= stage_item;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[fdtd_pml_pkg::DIV_STAGES-1];
    assign out_quo   = div_reg[fdtd_pml_pkg::DIV_STAGES-1].quo;
    assign out_item  = item_reg[fdtd_pml_pkg::DIV_STAGES-1];

`ifndef SYNTHESIS
    // With a divisor between one and two, absorb lands between one half and one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_quo[fdtd_pml_pkg::Q_W-1:fdtd_pml_pkg::Q_W-2] != 2'b00)
            && (!out_quo[fdtd_pml_pkg::Q_W-1] || (out_quo[fdtd_pml_pkg::Q_W-2:0] == '0)))
        else $error("div: absorb out of range");
`endif

endmodule

FILE: rtl/core/fdtd_pml_back.sv
// Back end: decay and curl coefficient, the two products, rounding, sum and saturation.
// Four stages, the last one is the output register; depends on fdtd_pml_pkg.
module fdtd_pml_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   ce,
    input  logic                                   in_valid,
    input  logic [fdtd_pml_pkg::Q_W-1:0]           in_quo,
    input  fdtd_pml_pkg::item_t                    in_item,
    output logic                                   out_valid,
    output logic [fdtd_pml_pkg::FIELD_WIDTH-1:0]   out_value,
    output logic                                   out_sat
);

    localparam int FW = fdtd_pml_pkg::FIELD_WIDTH;
    localparam int CW = fdtd_pml_pkg::CURL_W;
    localparam int SW = fdtd_pml_pkg::SUM_W;

    // Stage B1: coefficients and magnitudes
    logic                                   b1_valid_reg;
    logic                                   b1_nop_reg;
    logic                                   b1_sat_reg;
    logic [FW-1:0]                          b1_old_reg;
    logic [fdtd_pml_pkg::Q_W-1:0]           b1_decay_reg;
    logic [fdtd_pml_pkg::COEF_W-1:0]        b1_coef_reg;
    logic [FW-1:0]                          b1_mold_reg;
    logic [CW-1:0]                          b1_mcurl_reg;
    logic                                   b1_sold_reg;
    logic                                   b1_scurl_reg;
    logic [fdtd_pml_pkg::Q_W:0]             decay_full;
    logic [fdtd_pml_pkg::Q_W+fdtd_pml_pkg::GAIN_W-1:0] coef_full;

    // Stage B2: products
    logic                                   b2_valid_reg;
    logic                                   b2_nop_reg;
    logic                                   b2_sat_reg;
    logic [FW-1:0]                          b2_old_reg;
    logic [fdtd_pml_pkg::PO_W-1:0]          b2_pold_reg;
    logic [fdtd_pml_pkg::PC_W-1:0]          b2_pcurl_reg;
    logic                                   b2_sold_reg;
    logic                                   b2_scurl_reg;

    // Stage B3: rounded signed terms
    logic                                   b3_valid_reg;
    logic                                   b3_nop_reg;
    logic                                   b3_sat_reg;
    logic [FW-1:0]                          b3_old_reg;
    logic signed [SW-1:0]                   b3_rold_reg;
    logic signed [SW-1:0]                   b3_rcurl_reg;
    logic [fdtd_pml_pkg::PO_W:0]            rnd_old;
    logic [fdtd_pml_pkg::PC_W:0]            rnd_curl;
    logic signed [SW-1:0]                   mag_old;
    logic signed [SW-1:0]                   mag_curl;

    // Stage B4: output register
    logic                                   b4_valid_reg;
    logic [FW-1:0]                          b4_value_reg;
    logic [FW-1:0]                          b4_value_next;
    logic                                   b4_sat_reg;
    logic                                   b4_sat_next;
    logic signed [SW-1:0]                   sum;
    logic                                   in_range;

    // B1: decay = 2*absorb - 1, coef = round(absorb * gain / 2^16)
    assign decay_full = {in_quo, 1'b0} - (fdtd_pml_pkg::Q_W+1)'(64'h8000_0000);
    assign coef_full  = (fdtd_pml_pkg::Q_W+fdtd_pml_pkg::GAIN_W)'(in_quo) * in_item.gain
                        + (fdtd_pml_pkg::Q_W+fdtd_pml_pkg::GAIN_W)'(17'h08000);

    // B3: divide each product by 2^31, rounding the magnitude half up
    assign rnd_old  = (fdtd_pml_pkg::PO_W+1)'(b2_pold_reg) + (fdtd_pml_pkg::PO_W+1)'(64'h4000_0000);
    assign rnd_curl = (fdtd_pml_pkg::PC_W+1)'(b2_pcurl_reg) + (fdtd_pml_pkg::PC_W+1)'(64'h4000_0000);
    assign mag_old  = SW'(rnd_old[fdtd_pml_pkg::PO_W:31]);
    assign mag_curl = SW'(rnd_curl[fdtd_pml_pkg::PC_W:31]);

    // B4: add, then clip to the field range when the upper bits disagree; nop items keep the old value
    assign sum      = b3_rold_reg + b3_rcurl_reg;
    assign in_range = (sum[SW-1:FW-1] == '0) || (sum[SW-1:FW-1] == '1);

    always_comb
    begin
        if (b3_nop_reg)
        begin
            b4_value_next = b3_old_reg;
            b4_sat_next   = 1'b0;
        end
        else if (in_range)
        begin
            b4_value_next = sum[FW-1:0];
            b4_sat_next   = b3_sat_reg;
        end
        else
        begin
            b4_value_next = {sum[SW-1], {(FW-1){~sum[SW-1]}}};
            b4_sat_next   = 1'b1;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            b1_nop_reg   <= in_item.nop;
            b1_sat_reg   <= in_item.sat;
            b1_old_reg   <= in_item.old;
            b1_decay_reg <= decay_full[fdtd_pml_pkg::Q_W-1:0];
            b1_coef_reg  <= coef_full[16 +: fdtd_pml_pkg::COEF_W];
            b1_sold_reg  <= in_item.old[FW-1];
            b1_scurl_reg <= in_item.curl[CW-1];
            b1_mold_reg  <= in_item.old[FW-1] ? (~in_item.old + FW'(1)) : in_item.old;
            b1_mcurl_reg <= in_item.curl[CW-1] ? (~in_item.curl + CW'(1)) : in_item.curl;

            b2_nop_reg   <= b1_nop_reg;
            b2_sat_reg   <= b1_sat_reg;
            b2_old_reg   <= b1_old_reg;
            b2_sold_reg  <= b1_sold_reg;
            b2_scurl_reg <= b1_scurl_reg;
            b2_pold_reg  <= fdtd_pml_pkg::PO_W'(b1_mold_reg) * b1_decay_reg;
            b2_pcurl_reg <= fdtd_pml_pkg::PC_W'(b1_mcurl_reg) * b1_coef_reg;

            b3_nop_reg   <= b2_nop_reg;
            b3_sat_reg   <= b2_sat_reg;
            b3_old_reg   <= b2_old_reg;
            b3_rold_reg  <= b2_sold_reg ? -mag_old : mag_old;
            b3_rcurl_reg <= b2_scurl_reg ? -mag_curl : mag_curl;

            b4_value_reg <= b4_value_next;
            b4_sat_reg   <= b4_sat_next;
        end
    end

    assign out_valid = b4_valid_reg;
    assign out_value = b4_value_reg;
    assign out_sat   = b4_sat_reg;

`ifndef SYNTHESIS
    // An item with the unused command passes its old value through unflagged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ce && b3_valid_reg && b3_nop_reg) |=> (b4_valid_reg && !b4_sat_reg
            && (b4_value_reg == $past(b3_old_reg))))
        else $error("back: pass-through word altered");
`endif

endmodule

FILE: rtl/core/fdtd_2d_cell_update_pml_top.sv
// Top level of the FDTD cell update kernel: register file, stream ports, pipeline enable.
// Depends on fdtd_pml_pkg, fdtd_pml_front, fdtd_pml_div and fdtd_pml_back.

// One cell update per word, fully pipelined: a new word is taken on every clock while the
// pipeline is not halted. A word passes 3 front-end stages for the loss term and
// dielectric scaling, 16 stages of the two-bit-per-stage reciprocal divider and 4 back-end
// stages for the products, rounding and saturation, the last being the output register.
// The whole pipeline advances together; it halts only while a result sits on the output and
// the sink does not take it; s_tready is low exactly then. The user must write registers
// through the cfg port only while no word is in flight; the block does not enforce this.
module fdtd_2d_cell_update_pml_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // tdata: old_value, field_a, field_b, field_c, field_d (32 each), sigma_x, sigma_y
    // (16 each), in_dielectric (1), zero fill
    input  logic [fdtd_pml_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser: command
    input  logic [fdtd_pml_pkg::CMD_W-1:0]          s_tuser,
    // Output stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // tdata: new_value
    output logic [fdtd_pml_pkg::OUT_DATA_W-1:0]     m_tdata,
    // tuser: saturated
    output logic                                    m_tuser,
    // Register write port
    input  logic                                    cfg_write,
    input  logic [fdtd_pml_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fdtd_pml_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int FW = fdtd_pml_pkg::FIELD_WIDTH;
    localparam int SG = fdtd_pml_pkg::SIGMA_W;

    logic [fdtd_pml_pkg::LOSS_W-1:0]  h_loss_reg;
    logic [fdtd_pml_pkg::LOSS_W-1:0]  e_loss_reg;
    logic [fdtd_pml_pkg::GAIN_W-1:0]  h_gain_reg;
    logic [fdtd_pml_pkg::GAIN_W-1:0]  e_gain_reg;
    logic [fdtd_pml_pkg::INV_W-1:0]   inv_reg;
    fdtd_pml_pkg::cfg_t               cfg;
    logic                             ce;

    logic                             front_valid;
    fdtd_pml_pkg::div_t               front_div;
    fdtd_pml_pkg::item_t              front_item;
    logic                             div_valid;
    logic [fdtd_pml_pkg::Q_W-1:0]     div_quo;
    fdtd_pml_pkg::item_t              div_item;
    logic [FW-1:0]                    new_value;
    logic                             saturated;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_loss_reg <= '0;
            e_loss_reg <= '0;
            h_gain_reg <= fdtd_pml_pkg::GAIN_RESET;
            e_gain_reg <= fdtd_pml_pkg::GAIN_RESET;
            inv_reg    <= fdtd_pml_pkg::INV_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fdtd_pml_pkg::REG_H_LOSS: h_loss_reg <= cfg_data;
                fdtd_pml_pkg::REG_E_LOSS: e_loss_reg <= cfg_data;
                fdtd_pml_pkg::REG_H_GAIN: h_gain_reg <= cfg_data[fdtd_pml_pkg::GAIN_W-1:0];
                fdtd_pml_pkg::REG_E_GAIN: e_gain_reg <= cfg_data[fdtd_pml_pkg::GAIN_W-1:0];
                fdtd_pml_pkg::REG_INV:    inv_reg    <= cfg_data[fdtd_pml_pkg::INV_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Permittivity reciprocal is limited to one
    always_comb
    begin
        cfg.h_loss = h_loss_reg;
        cfg.e_loss = e_loss_reg;
        cfg.h_gain = h_gain_reg;
        cfg.e_gain = e_gain_reg;
        cfg.inv    = (inv_reg > fdtd_pml_pkg::INV_ONE) ? fdtd_pml_pkg::INV_ONE : inv_reg;
    end

    // The pipeline moves whenever the output register is free or being emptied
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    fdtd_pml_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .ce            (ce),
        .in_valid      (s_tvalid),
        .command       (s_tuser),
        .old_value     (s_tdata[0 +: FW]),
        .field_a       (s_tdata[FW +: FW]),
        .field_b       (s_tdata[2*FW +: FW]),
        .field_c       (s_tdata[3*FW +: FW]),
        .field_d       (s_tdata[4*FW +: FW]),
        .sigma_x       (s_tdata[5*FW +: SG]),
        .sigma_y       (s_tdata[5*FW+SG +: SG]),
        .in_dielectric (s_tdata[5*FW+2*SG]),
        .cfg           (cfg),
        .out_valid     (front_valid),
        .out_div       (front_div),
        .out_item      (front_item)
    );

    fdtd_pml_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (front_valid),
        .in_div    (front_div),
        .in_item   (front_item),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_item  (div_item)
    );

    fdtd_pml_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (div_valid),
        .in_quo    (div_quo),
        .in_item   (div_item),
        .out_valid (m_tvalid),
        .out_value (new_value),
        .out_sat   (saturated)
    );

    assign m_tdata = fdtd_pml_pkg::OUT_DATA_W'(new_value);
    assign m_tuser = saturated;

endmodule

FILE: tb/sv/fdtd_2d_cell_update_pml_top_tb.sv
// Self-checking testbench for the FDTD cell update kernel with an absorbing layer.
// Needs fdtd_pml_pkg and fdtd_2d_cell_update_pml_top; a built-in cell predictor checks each word.
`timescale 1ns / 100ps

module fdtd_2d_cell_update_pml_top_tb;

    // Expected output word of one cell update
    typedef struct {
        logic [31:0] value;
        logic        sat;
    } cell_result_t;

    // Keeps the register copy, predicts each update and checks the outputs in order
    class cell_scoreboard;
        logic [31:0] h_loss, e_loss;
        logic [17:0] h_gain, e_gain;
        logic [16:0] inv_perm;
        cell_result_t pending[$];
        int errors;

        function new();
            h_loss = 0;
            e_loss = 0;
            h_gain = fdtd_pml_pkg::GAIN_RESET;
            e_gain = fdtd_pml_pkg::GAIN_RESET;
            inv_perm = fdtd_pml_pkg::INV_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                fdtd_pml_pkg::REG_H_LOSS: h_loss = val;
                fdtd_pml_pkg::REG_E_LOSS: e_loss = val;
                fdtd_pml_pkg::REG_H_GAIN: h_gain = val[17:0];
                fdtd_pml_pkg::REG_E_GAIN: e_gain = val[17:0];
                fdtd_pml_pkg::REG_INV:    inv_perm = val[16:0];
                default: ;
            endcase
        endfunction

        // Signed value times coefficient over 2^31, rounded half away from zero
        function longint scale_q31(longint v, logic [63:0] c);
            logic [127:0] mag, prod;
            mag = v < 0 ? -v : v;
            prod = (mag * c + (128'd1 << 30)) >> 31;
            return v < 0 ? -longint'(prod) : longint'(prod);
        endfunction

        function void note_input(logic [1:0] cmd, logic signed [31:0] old_v,
                                 logic signed [31:0] fa, logic signed [31:0] fb,
                                 logic signed [31:0] fc, logic signed [31:0] fd,
                                 logic [15:0] sx, logic [15:0] sy, logic diel);
            logic [63:0] loss, gain, absorb, decay, coef, den, inv;
            logic [127:0] wide;
            longint curl, res;
            cell_result_t r;
            r.sat = 0;
            inv = inv_perm > fdtd_pml_pkg::INV_ONE ? 64'(fdtd_pml_pkg::INV_ONE)
                                                   : 64'(inv_perm);
            if (cmd == fdtd_pml_pkg::CMD_NOP) begin
                r.value = old_v;
                pending.push_back(r);
                return;
            end
            if (cmd == fdtd_pml_pkg::CMD_HX) begin
                loss = sx * h_loss;
                gain = h_gain;
                curl = longint'(fb) - longint'(fa);
            end else if (cmd == fdtd_pml_pkg::CMD_HZ) begin
                loss = sy * h_loss;
                gain = h_gain;
                curl = longint'(fa) - longint'(fb);
            end else begin
                loss = (64'(sx) + 64'(sy)) * e_loss;
                gain = e_gain;
                if (diel) begin
                    loss = (loss >> 16) * inv + (((loss & 64'hFFFF) * inv + 64'h8000) >> 16);
                    gain = (64'(e_gain) * inv + 64'h8000) >> 16;
                end
                curl = (longint'(fa) - longint'(fb)) - (longint'(fc) - longint'(fd));
            end
            // Loss above one is clipped
            if (loss > 64'h1_0000_0000) begin
                loss = 64'h1_0000_0000;
                r.sat = 1;
            end
            den = 64'h1_0000_0000 + loss;
            wide = ((128'd1 << 63) + (den >> 1)) / den;
            absorb = wide[63:0];
            decay = 2 * absorb - (64'd1 << 31);
            coef = (absorb * gain + 64'h8000) >> 16;
            res = scale_q31(old_v, decay) + scale_q31(curl, coef);
            if (res > 64'sh7FFF_FFFF) begin
                res = 64'sh7FFF_FFFF;
                r.sat = 1;
            end else if (res < -64'sh8000_0000) begin
                res = -64'sh8000_0000;
                r.sat = 1;
            end
            r.value = res[31:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] value, logic sat);
            cell_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected output word: new_value %h", value);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (value !== e.value) begin
                $error("new_value expected %h actual %h", e.value, value);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated expected %b actual %b", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic s_tvalid, s_tready;
    logic [fdtd_pml_pkg::IN_DATA_W-1:0] s_tdata;
    logic [fdtd_pml_pkg::CMD_W-1:0] s_tuser;
    logic m_tvalid, m_tready;
    logic [fdtd_pml_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_write;
    logic [fdtd_pml_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fdtd_pml_pkg::CFG_DATA_W-1:0] cfg_data;

    cell_scoreboard board;
    bit sink_stalls;
    int sink_hold;

    fdtd_2d_cell_update_pml_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Output side: random back-pressure with occasional long stalls, check every accepted word
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if (sink_hold > 0) begin
                sink_hold = sink_hold - 1;
                m_tready <= 1'b0;
            end else if (sink_stalls && ($urandom_range(99) < 3)) begin
                sink_hold = $urandom_range(40, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= sink_stalls ? ($urandom_range(3) != 0) : 1'b1;
            end
        end
    end

    // Sends one word and waits for its acceptance; valid stays high when no gap follows
    task automatic send_cell(logic [1:0] cmd, logic [31:0] old_v, logic [31:0] fa,
                             logic [31:0] fb, logic [31:0] fc, logic [31:0] fd,
                             logic [15:0] sx, logic [15:0] sy, logic diel);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, diel, sy, sx, fd, fc, fb, fa, old_v};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_input(cmd, old_v, fa, fb, fc, fd, sx, sy, diel);
    endtask

    task automatic send_random(int cmd_mode);
        logic [1:0] cmd;
        logic [31:0] v[5];
        logic [15:0] sx, sy;
        foreach (v[i])
            case ($urandom_range(4))
                0: v[i] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                1: v[i] = $signed(16'($urandom)) ;
                default: v[i] = $urandom;
            endcase
        sx = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
        sy = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
        if ($urandom_range(1)) begin
            sx = sx >> $urandom_range(15);
            sy = sy >> $urandom_range(15);
        end
        cmd = (cmd_mode < 0) ? 2'($urandom_range(3)) : 2'(cmd_mode);
        send_cell(cmd, v[0], v[1], v[2], v[3], v[4], sx, sy, 1'($urandom));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 0;
        board.write_reg(idx, val);
    endtask

    // Drops valid, then waits for every outstanding result plus the pipeline depth
    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Small loss values keep most cells inside the layer's useful range; extreme mode writes limit values
    task automatic random_config(bit extreme);
        write_reg(fdtd_pml_pkg::REG_H_LOSS,
                  extreme ? 32'hFFFF_FFFF : 32'($urandom_range(200000)));
        write_reg(fdtd_pml_pkg::REG_E_LOSS, extreme ? 32'd0 : 32'($urandom_range(200000)));
        write_reg(fdtd_pml_pkg::REG_H_GAIN, extreme ? 32'h3FFFF : 32'($urandom_range(262143)));
        write_reg(fdtd_pml_pkg::REG_E_GAIN, extreme ? 32'd0 : 32'($urandom_range(262143)));
        write_reg(fdtd_pml_pkg::REG_INV, extreme ? 32'h1FFFF : 32'($urandom_range(65536)));
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = fdtd_pml_pkg::CMD_HX;
        m_tready = 0;
        cfg_write = 0;
        cfg_index = fdtd_pml_pkg::REG_H_LOSS;
        cfg_data = '0;
        sink_stalls = 1;
        sink_hold = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // Directed cells at reset settings: each command, field extremes, saturation
        send_cell(fdtd_pml_pkg::CMD_HX, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                  0, 0, 0, 0, 0);
        send_cell(fdtd_pml_pkg::CMD_HZ, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  0, 0, 0, 0, 0);
        send_cell(fdtd_pml_pkg::CMD_EY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1);
        send_cell(fdtd_pml_pkg::CMD_EY, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        send_cell(fdtd_pml_pkg::CMD_NOP, 32'h8765_4321, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0,
                  16'hFFFF, 16'hFFFF, 1);
        send_cell(fdtd_pml_pkg::CMD_HX, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h5555_5555, 32'hAAAA_AAAA, 16'hFFFF, 0, 1);
        drain();

        // Loss above one, gain and permittivity extremes
        random_config(1);
        send_cell(fdtd_pml_pkg::CMD_HX, 32'h0100_0000, 0, 32'h0001_0000, 0, 0,
                  16'hFFFF, 0, 0);
        send_cell(fdtd_pml_pkg::CMD_HZ, 32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                  0, 16'd1, 0);
        send_cell(fdtd_pml_pkg::CMD_HZ, 32'h0100_0000, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
        send_cell(fdtd_pml_pkg::CMD_EY, 32'h0100_0000, 32'h0001_0000, 0, 0, 0,
                  16'hFFFF, 16'hFFFF, 1);
        drain();
        write_reg(fdtd_pml_pkg::REG_E_LOSS, 32'hFFFF_FFFF);
        write_reg(fdtd_pml_pkg::REG_E_GAIN, 32'h3FFFF);
        write_reg(fdtd_pml_pkg::REG_INV, 32'd0);
        send_cell(fdtd_pml_pkg::CMD_EY, 32'h0100_0000, 32'h0400_0000, 0, 0, 32'h0400_0000,
                  1, 1, 1);
        send_cell(fdtd_pml_pkg::CMD_EY, 32'h0100_0000, 32'h0400_0000, 0, 0, 32'h0400_0000,
                  1, 0, 0);
        drain();

        // Random phases with fresh settings; one phase without back-pressure
        for (int phase = 0; phase < 8; phase++) begin
            random_config(0);
            sink_stalls = (phase != 3);
            for (int i = 0; i < 125; i++) begin
                send_random(-1);
                // Sender holds off until the pipeline is empty
                if (i == 60) begin
                    s_tvalid <= 0;
                    while (board.pending.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
